/* rtl/itda_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// itda_pkg
// Shared constants, types and sizing helpers for the decimal text converter.
// ============================================================================
package itda_pkg;

    localparam int DEF_INPUT_WIDTH = 32;
    localparam int BITS_PER_STEP   = 4;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;

    typedef enum logic [1:0] {
        CONV_IDLE,
        CONV_RUN,
        CONV_DONE
    } conv_state_t;

    // Upper bound on the decimal digits of a magnitude up to 2**(w-1);
    // 78/256 sits just above log10(2).
    function automatic int digit_count(input int w);
        return ((w * 78) >> 8) + 1;
    endfunction

    // Magnitude width rounded up to whole conversion steps.
    function automatic int padded_width(input int w);
        return ((w + BITS_PER_STEP - 1) / BITS_PER_STEP) * BITS_PER_STEP;
    endfunction

endpackage

/* rtl/itda_front.sv */
`timescale 1ns / 1ps
// ============================================================================
// itda_front
// Accept integers, split them into sign and unsigned magnitude, queue them.
// ============================================================================
module itda_front #(
    parameter int INPUT_WIDTH = itda_pkg::DEF_INPUT_WIDTH
) (
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [INPUT_WIDTH-1:0] value,
    output logic                   q_push,
    input  logic                   q_ready,
    output logic [INPUT_WIDTH:0]   q_entry
);
    import itda_pkg::*;

    logic                   neg;
    logic [INPUT_WIDTH-1:0] mag;

    // Magnitude is unsigned, so the most negative value stays exact.
    assign neg      = value[INPUT_WIDTH-1];
    assign mag      = neg ? (~value + INPUT_WIDTH'(1)) : value;
    assign in_ready = q_ready;
    assign q_push   = in_valid && q_ready;
    assign q_entry  = {neg, mag};

endmodule

/* rtl/itda_queue.sv */
`timescale 1ns / 1ps
// ============================================================================
// itda_queue
// Short FIFO between the classifying front and the conversion back end.
// ============================================================================
module itda_queue #(
    parameter int ENTRY_WIDTH = itda_pkg::DEF_INPUT_WIDTH + 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [ENTRY_WIDTH-1:0] push_data,
    output logic                   push_ready,
    input  logic                   pop,
    output logic                   pop_valid,
    output logic [ENTRY_WIDTH-1:0] pop_data
);
    import itda_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [ENTRY_WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");
`endif

endmodule

/* rtl/itda_conv.sv */
`timescale 1ns / 1ps
// ============================================================================
// itda_conv
// Binary to BCD by shift-and-add-3, four magnitude bits per cycle.
// ============================================================================
module itda_conv #(
    parameter int INPUT_WIDTH = itda_pkg::DEF_INPUT_WIDTH
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        q_valid,
    input  logic [INPUT_WIDTH:0]                        q_entry,
    output logic                                        q_pop,
    output logic                                        res_valid,
    input  logic                                        res_ready,
    output logic                                        res_neg,
    output logic [itda_pkg::digit_count(INPUT_WIDTH)*4-1:0] res_bcd
);
    import itda_pkg::*;

    localparam int NDIG    = digit_count(INPUT_WIDTH);
    localparam int BCD_W   = NDIG * 4;
    localparam int MAG_PAD = padded_width(INPUT_WIDTH);
    localparam int STEPS   = MAG_PAD / BITS_PER_STEP;
    localparam int STEP_W  = (STEPS > 1) ? $clog2(STEPS) : 1;

    conv_state_t        state_reg, state_next;
    logic [MAG_PAD-1:0] shift_reg;
    logic [BCD_W-1:0]   bcd_reg;
    logic [BCD_W-1:0]   bcd_step;
    logic               neg_reg;
    logic [STEP_W-1:0]  step_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CONV_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = CONV_RUN;
                end
            end
            CONV_RUN:
            begin
                if (step_reg == '0)
                begin
                    state_next = CONV_DONE;
                end
            end
            CONV_DONE:
            begin
                if (res_ready)
                begin
                    state_next = CONV_IDLE;
                end
            end
            default: state_next = CONV_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        q_pop     = 1'b0;
        res_valid = 1'b0;
        unique case (state_reg)
            CONV_IDLE: q_pop     = q_valid;
            CONV_RUN:  q_pop     = 1'b0;
            CONV_DONE: res_valid = 1'b1;
            default:   q_pop     = 1'b0;
        endcase
    end

    assign res_neg = neg_reg;
    assign res_bcd = bcd_reg;

    // Four dabble steps: correct each digit, then shift in the next bit.
    always_comb
    begin
        logic [BCD_W-1:0] acc;
        acc = bcd_reg;
        for (int k = 0; k < BITS_PER_STEP; k++)
        begin
            for (int d = 0; d < NDIG; d++)
            begin
                if (acc[d*4 +: 4] >= 4'd5)
                begin
                    acc[d*4 +: 4] = acc[d*4 +: 4] + 4'd3;
                end
            end
            acc = {acc[BCD_W-2:0], shift_reg[MAG_PAD-1-k]};
        end
        bcd_step = acc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CONV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            shift_reg <= MAG_PAD'(q_entry[INPUT_WIDTH-1:0]);
            neg_reg   <= q_entry[INPUT_WIDTH];
            bcd_reg   <= '0;
            step_reg  <= STEP_W'(STEPS - 1);
        end
        else if (state_reg == CONV_RUN)
        begin
            shift_reg <= shift_reg << BITS_PER_STEP;
            bcd_reg   <= bcd_step;
            step_reg  <= step_reg - STEP_W'(1);
        end
    end

`ifndef SYNTHESIS
    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg == CONV_RUN))
        else $error("conversion did not start after queue pop");
`endif

endmodule

/* rtl/itda_emit.sv */
`timescale 1ns / 1ps
// ============================================================================
// itda_emit
// Walk the BCD digits from the top, skip leading zeros, drive the output.
// ============================================================================
module itda_emit #(
    parameter int INPUT_WIDTH = itda_pkg::DEF_INPUT_WIDTH
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        res_valid,
    output logic                                        res_ready,
    input  logic                                        res_neg,
    input  logic [itda_pkg::digit_count(INPUT_WIDTH)*4-1:0] res_bcd,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic [7:0]                                  character,
    output logic                                        last
);
    import itda_pkg::*;

    localparam int NDIG  = digit_count(INPUT_WIDTH);
    localparam int CNT_W = $clog2(NDIG + 1);
    localparam int IDX_W = $clog2(NDIG);

    logic [NDIG-1:0][3:0] bcd_reg, bcd_next;
    logic [NDIG-1:0][3:0] res_digits;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     used_cnt;
    logic [IDX_W-1:0]     idx;
    logic                 busy_reg, busy_next;
    logic                 neg_pend_reg, neg_pend_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           char_reg, char_next;
    logic                 last_reg, last_next;
    logic                 adv;
    logic                 finishing;
    logic                 load;

    assign res_digits = res_bcd;
    assign idx        = IDX_W'(cnt_reg - CNT_W'(1));
    assign adv        = !out_valid_reg || out_ready;
    assign finishing  = busy_reg && adv && !neg_pend_reg && (cnt_reg == CNT_W'(1));
    assign res_ready  = !busy_reg || finishing;
    assign load       = res_valid && res_ready;

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

    // Digits in use: highest nonzero digit, at least one for zero.
    always_comb
    begin
        used_cnt = CNT_W'(1);
        for (int d = 0; d < NDIG; d++)
        begin
            if (res_digits[d] != 4'd0)
            begin
                used_cnt = CNT_W'(d + 1);
            end
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        neg_pend_next  = neg_pend_reg;
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        if (adv)
        begin
            out_valid_next = busy_reg;
            if (busy_reg)
            begin
                if (neg_pend_reg)
                begin
                    char_next     = CHAR_MINUS;
                    last_next     = 1'b0;
                    neg_pend_next = 1'b0;
                end
                else
                begin
                    char_next = CHAR_ZERO + {4'd0, bcd_reg[idx]};
                    last_next = (cnt_reg == CNT_W'(1));
                    cnt_next  = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        busy_next = 1'b0;
                    end
                end
            end
        end
        if (load)
        begin
            busy_next     = 1'b1;
            neg_pend_next = res_neg;
            bcd_next      = res_digits;
            cnt_next      = used_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            neg_pend_reg  <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            neg_pend_reg  <= neg_pend_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

`ifndef SYNTHESIS
    a_busy_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != '0))
        else $error("emitter busy with no digits left");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(NDIG))
        else $error("digit count beyond digit store");

    a_sign_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        neg_pend_reg |-> busy_reg)
        else $error("pending minus sign while emitter idle");
`endif

endmodule

/* rtl/int_to_decimal_ascii_unit.sv */
`timescale 1ns / 1ps
// ============================================================================
// int_to_decimal_ascii_unit
// Signed integer to decimal ASCII text, one character per output transfer.
// ============================================================================
// Each input transfer carries one two's-complement integer; the unit returns
// its decimal text most significant character first, a leading '-' for a
// negative value, no leading zeros, and last set on the final character.
// Zero gives the single character '0'; the most negative value is converted
// exactly (11 characters at the default 32-bit width). The BCD converter
// takes no new item until the output stage has taken its last result, and
// the output stage sends one character per cycle while the receiver is
// ready. The converter works on the next item while the text of the last
// one is still going out. A two-entry queue sits between the classifying
// front and the converter, so inputs keep being taken while text is still
// going out.
module int_to_decimal_ascii_unit #(
    parameter int INPUT_WIDTH = itda_pkg::DEF_INPUT_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [INPUT_WIDTH-1:0] value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             character,
    output logic                   last
);
    import itda_pkg::*;

    localparam int NDIG = digit_count(INPUT_WIDTH);

    // Front to queue: sign bit over magnitude
    logic                 q_push;
    logic                 q_push_ready;
    logic [INPUT_WIDTH:0] q_push_entry;

    // Queue to converter
    logic                 q_pop;
    logic                 q_valid;
    logic [INPUT_WIDTH:0] q_pop_entry;

    // Converter to emitter
    logic                 res_valid;
    logic                 res_ready;
    logic                 res_neg;
    logic [NDIG*4-1:0]    res_bcd;

    // Classify: take the transfer, split sign and magnitude
    itda_front #(
        .INPUT_WIDTH (INPUT_WIDTH)
    ) u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .value    (value),
        .q_push   (q_push),
        .q_ready  (q_push_ready),
        .q_entry  (q_push_entry)
    );

    // Decouple front and back so each can stall on its own
    itda_queue #(
        .ENTRY_WIDTH (INPUT_WIDTH + 1)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_entry),
        .push_ready (q_push_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_data   (q_pop_entry)
    );

    // Convert the magnitude to BCD, four bits a cycle
    itda_conv #(
        .INPUT_WIDTH (INPUT_WIDTH)
    ) u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_pop_entry),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_neg   (res_neg),
        .res_bcd   (res_bcd)
    );

    // Send sign and significant digits through the output register
    itda_emit #(
        .INPUT_WIDTH (INPUT_WIDTH)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_neg   (res_neg),
        .res_bcd   (res_bcd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last      (last)
    );

endmodule

/* tb/int_to_decimal_ascii_unit_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// int_to_decimal_ascii_unit_test
// Self-checking bench for the signed integer to decimal text converter.
// ============================================================================
// Feeds 32-bit integers through the input channel and compares every
// character that leaves the output channel with a predicted text stream.
// A short table covers zero, the signed extremes, digit-count boundaries
// and both signs. Random values follow: full-range words, short magnitudes,
// values next to powers of ten, and values near the extremes. Both sides
// insert random idle cycles, except in one quiet stretch. At one point the
// receiver holds off for a long run of cycles so that the unit fills up and
// stalls its input.
// ============================================================================
module int_to_decimal_ascii_unit_test;

    localparam int VALUE_W      = itda_pkg::DEF_INPUT_WIDTH;
    localparam int TABLE_ROWS   = 20;
    localparam int RANDOM_ITEMS = 160;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 15;

    // One character of expected text.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [VALUE_W-1:0] value;
    logic               out_valid;
    logic               out_ready;
    logic [7:0]         character;
    logic               last;

    // Characters predicted for accepted values, oldest first.
    text_char_t pending_text[$];

    int  mismatches;
    int  values_taken;
    int  cycles;
    bit  gaps_on;
    bit  hold_rx;

    logic [VALUE_W-1:0] table_value [TABLE_ROWS];
    string              table_text  [TABLE_ROWS];

    int_to_decimal_ascii_unit #(
        .INPUT_WIDTH(VALUE_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .value    (value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .character(character),
        .last     (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Append the decimal text of v: sign first, then digits most
    // significant first, last flag on the final digit.
    function automatic void predict_decimal_text(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] mag;
        logic [7:0]         digits [20];
        int                 nd;
        bit                 negative;
        negative = v[VALUE_W-1];
        // Two's-complement negate as unsigned, so the most negative value
        // keeps its full magnitude.
        mag = negative ? (~v + 1'b1) : v;
        nd = 0;
        do
        begin
            digits[nd] = 8'(mag % 10);
            nd++;
            mag = mag / 10;
        end
        while (mag != 0);
        if (negative)
            pending_text.push_back('{ch: itda_pkg::CHAR_MINUS, last: 1'b0});
        for (int i = nd - 1; i >= 0; i--)
            pending_text.push_back('{ch: itda_pkg::CHAR_ZERO + digits[i], last: (i == 0)});
    endfunction

    // Append text typed in by hand.
    function automatic void push_typed_text(input string s);
        for (int i = 0; i < s.len(); i++)
            pending_text.push_back('{ch: s[i], last: (i == s.len() - 1)});
    endfunction

    // Draw a random value, weighted toward the interesting corners.
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] p;
        int                 k;
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = $urandom_range(0, 99);
            2:
            begin
                // Just below, at, or just above a power of ten.
                k = $urandom_range(0, 9);
                p = 1;
                repeat (k) p = p * 10;
                v = p + $urandom_range(0, 2) - 1;
            end
            3: v = $urandom_range(0, 1) ? (32'h8000_0000 + $urandom_range(0, 3))
                                        : (32'h7FFF_FFFF - $urandom_range(0, 3));
            default: v = $urandom >> $urandom_range(0, 31);
        endcase
        if ($urandom_range(0, 1) == 1)
            v = ~v + 1'b1;
        return v;
    endfunction

    // Offer one value and hold it until the transfer; queue its text then.
    // Return at the edge of the transfer so the next value can follow
    // without dropping valid.
    task automatic send_value(input logic [VALUE_W-1:0] v, input string text,
                              input bit gaps);
        if (gaps && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < IDLE_PCT);
        end
        in_valid <= 1'b1;
        value    <= v;
        do
            @(posedge clk);
        while (!in_ready);
        if (text.len() == 0)
            predict_decimal_text(v);
        else
            push_typed_text(text);
        values_taken++;
    endtask

    // Receiver: check each output transfer, then pick the next ready.
    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_text.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected character 0x%02h last=%0b", character, last);
                mismatches++;
            end
            else
            begin
                want = pending_text.pop_front();
                if (character !== want.ch || last !== want.last)
                begin
                    if (mismatches < 10)
                        $display({"character mismatch: expected 0x%02h last=%0b,",
                                  " got 0x%02h last=%0b"},
                                 want.ch, want.last, character, last);
                    mismatches++;
                end
            end
        end
        if (!rst_n || hold_rx)
            out_ready <= 1'b0;
        else
            out_ready <= !(gaps_on && $urandom_range(0, 99) < IDLE_PCT);
    end

    // Hold the receiver off once, long enough to back up the input.
    initial
    begin
        hold_rx = 1'b0;
        wait (values_taken >= TABLE_ROWS + 40);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
    end

    // Abort a run that hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("int_to_decimal_ascii_unit_test failed");
            $finish;
        end
    end

    initial
    begin
        bit gaps;
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        value        = '0;
        out_ready    = 1'b0;
        gaps_on      = 1'b1;
        mismatches   = 0;
        values_taken = 0;
        cycles       = 0;

        // Empty text means: take the expectation from the predictor.
        table_value = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10,
                        -32'sd9, -32'sd10, 32'd99, 32'd100, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h8000_0001, 32'd999_999_999,
                        32'd1_000_000_000, -32'sd1_000_000_000, 32'd12345,
                        32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000};
        table_text  = '{"0", "1", "-1", "9", "10",
                        "-9", "-10", "", "", "2147483647",
                        "-2147483648", "-2147483647", "", "1000000000",
                        "-1000000000", "", "", "", "", ""};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < TABLE_ROWS; i++)
            send_value(table_value[i], table_text[i], 1'b1);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Keep one stretch free of idle cycles on both sides.
            gaps = !(n >= 100 && n < 140);
            gaps_on <= gaps;
            send_value(pick_value(), "", gaps);
        end
        in_valid <= 1'b0;

        // Drain, then give the unit time to show any stray characters.
        while (pending_text.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatches == 0)
            $display("int_to_decimal_ascii_unit_test passed");
        else
            $display("int_to_decimal_ascii_unit_test failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/itda_pkg.sv
rtl/itda_front.sv
rtl/itda_queue.sv
rtl/itda_conv.sv
rtl/itda_emit.sv
rtl/int_to_decimal_ascii_unit.sv
tb/int_to_decimal_ascii_unit_test.sv
